// ===== rtl/core/tilt_complementary_filter_top_macros.svh =====
// tilt_complementary_filter_top_macros.svh: assertion macros for the tilt filter
// expects clk and rst_n in the scope where a macro is used
`ifndef TILT_COMPLEMENTARY_FILTER_TOP_MACROS_SVH
`define TILT_COMPLEMENTARY_FILTER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCF_ASSERT_IMM(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tilt filter check failed");

// next-cycle implication, disabled during reset
`define TCF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tilt filter check failed");

`endif

// ===== rtl/core/tcf_pkg.sv =====
// tcf_pkg.sv: constants, types and helpers of the tilt complementary filter
// no dependencies; used by the interfaces, tcf_cordic and the top level
package tcf_pkg;

  // cordic iteration count and datapath widths
  localparam int CORDIC_STEPS = 24;
  localparam int CNT_W        = $clog2(CORDIC_STEPS);
  localparam int XY_W         = 33;
  localparam int ANG_W        = 28;
  localparam int MA_W         = 33;
  localparam int MB_W         = 25;
  localparam int PROD_W       = MA_W + MB_W;
  localparam int MIX_W        = 52;

  // configuration word format
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // quarter turn in 2^-24 rad
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 28'sd26353589;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_PASS_GAIN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_PASS_GAIN   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_STEP_SCALE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_WEIGHT    = 8'd3;

  // register reset values
  localparam logic [16:0] HIGH_PASS_GAIN_RST  = 17'd64225;
  localparam logic [16:0] LOW_PASS_GAIN_RST   = 17'd1311;
  localparam logic [23:0] GYRO_STEP_SCALE_RST = 24'd1464100;
  localparam logic [16:0] CALIB_WEIGHT_RST    = 17'd655;

  // action codes
  localparam logic ACT_CALIB    = 1'b0;
  localparam logic ACT_ESTIMATE = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ROT,
    S_CAL_MUL_GB,
    S_CAL_MUL_TB,
    S_CAL_TB,
    S_EST_MUL_RATE,
    S_EST_PROP,
    S_EST_MUL_HP,
    S_EST_MUL_LP,
    S_EST_MIX,
    S_EST_OUT
  } tcf_state_t;

  // cordic unit status
  typedef struct packed {
    logic busy;
    logic done;
  } tcf_cordic_sts_t;

  // atan(2^-i) in 2^-24 rad, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 28'sd13176795;
      5'd1:    v = 28'sd7778716;
      5'd2:    v = 28'sd4110060;
      5'd3:    v = 28'sd2086331;
      5'd4:    v = 28'sd1047214;
      5'd5:    v = 28'sd524117;
      5'd6:    v = 28'sd262123;
      5'd7:    v = 28'sd131069;
      5'd8:    v = 28'sd65536;
      5'd9:    v = 28'sd32768;
      5'd10:   v = 28'sd16384;
      5'd11:   v = 28'sd8192;
      5'd12:   v = 28'sd4096;
      5'd13:   v = 28'sd2048;
      5'd14:   v = 28'sd1024;
      5'd15:   v = 28'sd512;
      5'd16:   v = 28'sd256;
      5'd17:   v = 28'sd128;
      5'd18:   v = 28'sd64;
      5'd19:   v = 28'sd32;
      5'd20:   v = 28'sd16;
      5'd21:   v = 28'sd8;
      5'd22:   v = 28'sd4;
      5'd23:   v = 28'sd2;
      5'd24:   v = 28'sd1;
      default: v = 28'sd0;
    endcase
    return v;
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/tcf_if.sv =====
// tcf_if.sv: valid/ready channels of the tilt filter (input, result, config)
// depends on tcf_pkg for the config word format

// input sample channel
interface tcf_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_y;

  modport source (output valid, action, accel_x, accel_z, gyro_y, input ready);
  modport sink   (input valid, action, accel_x, accel_z, gyro_y, output ready);
endinterface

// result channel
interface tcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle;

  modport source (output valid, angle, input ready);
  modport sink   (input valid, angle, output ready);
endinterface

// configuration write channel
interface tcf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcf_pkg::CFG_IDX_W-1:0]  index;
  logic [tcf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tcf_cordic.sv =====
// tcf_cordic.sv: iterative vectoring cordic for atan2(accel_x, accel_z)
// one micro-rotation per cycle; depends on tcf_pkg
module tcf_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [15:0]                accel_x,
  input  logic signed [15:0]                accel_z,
  output tcf_pkg::tcf_cordic_sts_t          sts,
  output logic signed [tcf_pkg::ANG_W-1:0]  tilt
);
  import tcf_pkg::*;

  logic signed [XY_W-1:0]  x_r, x_nxt;
  logic signed [XY_W-1:0]  y_r, y_nxt;
  logic signed [ANG_W-1:0] z_r, z_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    zero_r, zero_nxt;

  logic signed [XY_W-1:0]  ax_s, az_s;
  logic signed [XY_W-1:0]  x0, y0;
  logic signed [ANG_W-1:0] z0;
  logic signed [XY_W-1:0]  dx, dy;
  logic signed [ANG_W-1:0] ent;
  logic                    last;

  // inputs scaled by 2^14
  assign ax_s = {{(XY_W-30){accel_x[15]}}, accel_x, 14'b0};
  assign az_s = {{(XY_W-30){accel_z[15]}}, accel_z, 14'b0};

  // quarter-turn pre-rotation into the right half plane
  always_comb begin
    if (accel_z < 16'sd0) begin
      if (accel_x >= 16'sd0) begin
        x0 = ax_s;
        y0 = -az_s;
        z0 = QUARTER_TURN;
      end else begin
        x0 = -ax_s;
        y0 = az_s;
        z0 = -QUARTER_TURN;
      end
    end else begin
      x0 = az_s;
      y0 = ax_s;
      z0 = '0;
    end
  end

  // one micro-rotation
  assign dx   = y_r >>> cnt_r;
  assign dy   = x_r >>> cnt_r;
  assign ent  = atan_entry(5'(cnt_r));
  assign last = (cnt_r == CNT_W'(CORDIC_STEPS - 1));

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    zero_nxt = zero_r;
    if (start) begin
      x_nxt    = x0;
      y_nxt    = y0;
      z_nxt    = z0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      zero_nxt = (accel_x == 16'sd0) && (accel_z == 16'sd0);
    end else if (busy_r) begin
      if (y_r >= 0) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + ent;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - ent;
      end
      cnt_nxt  = cnt_r + 1'b1;
      busy_nxt = !last;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    cnt_r  <= cnt_nxt;
    zero_r <= zero_nxt;
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = busy_r && last;

  // both inputs zero give a zero angle
  assign tilt = zero_r ? '0 : z_r;

endmodule

// ===== rtl/core/tilt_complementary_filter_top.sv =====
// Tilt complementary filter, top level.
// Channels: in_bus (sink) takes one sample word: action, accel_x, accel_z,
// gyro_y. out_bus (source) gives the new angle for each estimate word.
// cfg_bus (sink) writes the gain registers, always ready; index 0 high-pass
// gain, 1 low-pass gain, 2 gyro step scale, 3 calibration weight; other
// indexes are dropped. Write registers only while the block is idle.
// A calibration word (action 0) updates the gyro and tilt biases and gives
// no result; an estimate word (action 1) updates the angle and returns it.
// atan2 runs on a cordic unit, one micro-rotation per cycle. Then a single
// shared 33x25 multiplier runs the products in turn: for a calibration
// word the gyro and tilt bias products, for an estimate word the gyro step,
// high-pass and low-pass products. A new word is taken only once the last
// one is through; in_bus.ready is high only between words.
// The angle sits in an output register; when the receiver stalls, the next
// word is still taken and processed, and its result waits in the last step
// until the previous angle is taken.
// Reset (rst_n low, synchronous) restores the default gains and clears the
// biases, the angle estimate and the result valid.
// Depends on tcf_pkg, tcf_if, tcf_cordic and the assertion macro header.
`include "tilt_complementary_filter_top_macros.svh"

module tilt_complementary_filter_top (
  input  logic      clk,
  input  logic      rst_n,
  tcf_in_if.sink    in_bus,
  tcf_out_if.source out_bus,
  tcf_cfg_if.sink   cfg_bus
);
  import tcf_pkg::*;

  // configuration registers
  logic [16:0] hpf_r;
  logic [16:0] lpf_r;
  logic [23:0] scale_r;
  logic [16:0] cw_r;

  // filter state
  logic signed [31:0] gyro_bias_r;
  logic signed [31:0] tilt_bias_r;
  logic signed [31:0] angle_r;

  // per-word working registers
  tcf_state_t           state_r, state_nxt;
  logic                 action_r;
  logic signed [15:0]   gy_r;
  logic signed [MA_W-1:0]   rate_r;
  logic signed [MA_W-1:0]   prop_r;
  logic signed [MA_W-1:0]   acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [MIX_W-1:0]  mix_r;
  logic                 out_valid_r, out_valid_nxt;

  // sequencer outputs
  logic                    in_acc;
  logic                    cordic_start;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic                    ld_gb, ld_tb, ld_prop, ld_acc, ld_mix0, ld_mix_add, ld_angle;

  tcf_cordic_sts_t         cordic_sts;
  logic signed [ANG_W-1:0] tilt;

  // arithmetic helpers
  logic signed [PROD_W-1:0] rnd16, rnd32;
  logic signed [MIX_W-1:0]  mix_rnd;
  logic signed [63:0]       gb_sum, tb_sum;
  logic signed [MA_W-1:0]   rate_in;
  logic                     out_free;

  // cordic unit
  tcf_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_start),
    .accel_x (in_bus.accel_x),
    .accel_z (in_bus.accel_z),
    .sts     (cordic_sts),
    .tilt    (tilt)
  );

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:         if (in_bus.valid) state_nxt = S_ROT;
      S_ROT: begin
        if (cordic_sts.done) begin
          state_nxt = (action_r == ACT_CALIB) ? S_CAL_MUL_GB : S_EST_MUL_RATE;
        end
      end
      S_CAL_MUL_GB:   state_nxt = S_CAL_MUL_TB;
      S_CAL_MUL_TB:   state_nxt = S_CAL_TB;
      S_CAL_TB:       state_nxt = S_IDLE;
      S_EST_MUL_RATE: state_nxt = S_EST_PROP;
      S_EST_PROP:     state_nxt = S_EST_MUL_HP;
      S_EST_MUL_HP:   state_nxt = S_EST_MUL_LP;
      S_EST_MUL_LP:   state_nxt = S_EST_MIX;
      S_EST_MIX:      state_nxt = S_EST_OUT;
      S_EST_OUT:      if (out_free) state_nxt = S_IDLE;
      default:        state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands and load strobes
  always_comb begin
    in_bus.ready = 1'b0;
    cordic_start = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    ld_gb        = 1'b0;
    ld_tb        = 1'b0;
    ld_prop      = 1'b0;
    ld_acc       = 1'b0;
    ld_mix0      = 1'b0;
    ld_mix_add   = 1'b0;
    ld_angle     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_bus.ready = 1'b1;
        cordic_start = in_bus.valid;
      end
      S_CAL_MUL_GB: begin
        mul_a = MA_W'(gy_r);
        mul_b = MB_W'(signed'({1'b0, cw_r}));
      end
      S_CAL_MUL_TB: begin
        ld_gb = 1'b1;
        mul_a = MA_W'(tilt);
        mul_b = MB_W'(signed'({1'b0, cw_r}));
      end
      S_CAL_TB: ld_tb = 1'b1;
      S_EST_MUL_RATE: begin
        ld_acc = 1'b1;
        mul_a  = rate_r;
        mul_b  = MB_W'(signed'({1'b0, scale_r}));
      end
      S_EST_PROP: ld_prop = 1'b1;
      S_EST_MUL_HP: begin
        mul_a = prop_r;
        mul_b = MB_W'(signed'({1'b0, hpf_r}));
      end
      S_EST_MUL_LP: begin
        ld_mix0 = 1'b1;
        mul_a   = acc_r;
        mul_b   = MB_W'(signed'({1'b0, lpf_r}));
      end
      S_EST_MIX: ld_mix_add = 1'b1;
      S_EST_OUT: ld_angle   = out_free;
      default: begin
        in_bus.ready = 1'b0;
      end
    endcase
  end

  // rounding adds: half an LSB of the result, ties toward plus infinity
  assign rnd16   = prod_r + {{(PROD_W-16){1'b0}}, 1'b1, 15'b0};
  assign rnd32   = prod_r + {{(PROD_W-32){1'b0}}, 1'b1, 31'b0};
  assign mix_rnd = mix_r + {{(MIX_W-16){1'b0}}, 1'b1, 15'b0};

  // bias accumulations before clamping
  assign gb_sum = 64'(gyro_bias_r) + 64'(prod_r);
  assign tb_sum = 64'(tilt_bias_r) + 64'(rnd16 >>> 16);

  // gyro rate in q16.16 less the bias
  assign rate_in = {in_bus.gyro_y[15], in_bus.gyro_y, 16'b0} - MA_W'(gyro_bias_r);

  // result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ld_angle) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hpf_r       <= HIGH_PASS_GAIN_RST;
      lpf_r       <= LOW_PASS_GAIN_RST;
      scale_r     <= GYRO_STEP_SCALE_RST;
      cw_r        <= CALIB_WEIGHT_RST;
      gyro_bias_r <= '0;
      tilt_bias_r <= '0;
      angle_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      // configuration writes
      if (cfg_bus.valid) begin
        case (cfg_bus.index)
          REG_HIGH_PASS_GAIN:  hpf_r   <= cfg_bus.data[16:0];
          REG_LOW_PASS_GAIN:   lpf_r   <= cfg_bus.data[16:0];
          REG_GYRO_STEP_SCALE: scale_r <= cfg_bus.data[23:0];
          REG_CALIB_WEIGHT:    cw_r    <= cfg_bus.data[16:0];
          default:             hpf_r   <= hpf_r;
        endcase
      end
      if (ld_gb) gyro_bias_r <= sat32(gb_sum);
      if (ld_tb) tilt_bias_r <= sat32(tb_sum);
      if (ld_angle) angle_r <= sat32(64'(mix_rnd >>> 16));
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_acc) begin
      action_r <= in_bus.action;
      gy_r     <= in_bus.gyro_y;
      rate_r   <= rate_in;
    end
    if (ld_acc) acc_r <= MA_W'(tilt) - MA_W'(tilt_bias_r);
    if (ld_prop) prop_r <= MA_W'(angle_r) + MA_W'(rnd32 >>> 32);
    if (ld_mix0) begin
      mix_r <= MIX_W'(prod_r);
    end else if (ld_mix_add) begin
      mix_r <= mix_r + MIX_W'(prod_r);
    end
  end

  assign cfg_bus.ready = 1'b1;
  assign out_bus.valid = out_valid_r;
  assign out_bus.angle = angle_r;

  // checks
  `TCF_ASSERT_NXT(a_accept_starts_cordic, in_acc, state_r == S_ROT && cordic_sts.busy)
  `TCF_ASSERT_IMM(a_rot_while_busy, state_r == S_ROT, cordic_sts.busy)
  `TCF_ASSERT_IMM(a_result_from_est, $rose(out_valid_r), $past(state_r) == S_EST_OUT)
  `TCF_ASSERT_IMM(a_angle_only_on_est, angle_r != $past(angle_r), $past(state_r) == S_EST_OUT)

endmodule
